// ===== rtl/assert_macros.svh =====
// Assertion macros for the allocator project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked on every edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/ffpa_pkg.sv =====
//------------------------------------------------------------------------------
// ffpa_pkg
// Types and constants shared by the first-fit pool allocator.
//------------------------------------------------------------------------------
`default_nettype none
package ffpa_pkg;
    localparam int POOL_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int ALIGN_BYTES_DEF  = 8;
    localparam int MAX_BLOCKS_DEF   = 128;
    localparam int GUARD_BYTES      = 4;
    localparam logic [11:0] MIN_SPLIT_RESET = 12'd32;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NO_FIT  = 3'd1;
    localparam logic [2:0] ST_ZERO    = 3'd2;
    localparam logic [2:0] ST_DOUBLE  = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;
    localparam logic [2:0] ST_NULL    = 3'd5;

    typedef struct packed {
        logic        cmd;
        logic [15:0] request_bytes;
        logic [11:0] data_offset_in;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] data_offset_out;
        logic [11:0] block_bytes;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,      // read stream over table, search
        S_DECIDE,    // entry found, choose action
        S_NEIGH,     // previous-neighbor merge check
        S_SHIFT_RD,  // shift loop read
        S_SHIFT_WR,  // shift loop write
        S_FINISH,    // final entry writes
        S_OUT        // result waits for consumer
    } state_t;
endpackage
`default_nettype wire

// ===== rtl/first_fit_pool_allocator.sv =====
//------------------------------------------------------------------------------
// first_fit_pool_allocator
// First-fit allocator over a block table held in one synchronous RAM.
//------------------------------------------------------------------------------
// One command is handled at a time. An allocate scans the table one entry per
// cycle until the first fitting free block. A split then moves every later
// entry up one place, with a read state and a write state per entry. A free
// scans for the block, and each merge then closes the gap in the same way. A
// zero-size or null word goes straight from accept to the output state. The
// longest walks are an allocate that splits at the table start and a free near
// the start of a full table that merges on both sides. These walks over the
// table RAM, with one read port and one write port, set the time per word. The
// result sits in an output register, and the next word is accepted once it has
// been taken.
`default_nettype none
`include "assert_macros.svh"
module first_fit_pool_allocator #(
    parameter int POOL_BYTES   = ffpa_pkg::POOL_BYTES_DEF,
    parameter int HEADER_BYTES = ffpa_pkg::HEADER_BYTES_DEF,
    parameter int ALIGN_BYTES  = ffpa_pkg::ALIGN_BYTES_DEF,
    parameter int MAX_BLOCKS   = ffpa_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [11:0]        cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ffpa_pkg::in_word_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ffpa_pkg::out_word_t     out_data
);
    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int PW = $clog2(POOL_BYTES + 1);
    // sizes/sums up to pool plus request; 18 bits covers rounding of 16-bit req
    localparam int SW = (PW > 17 ? PW : 17) + 2;
    localparam int EW = 2 * SW + 1;
    // reciprocal of ALIGN_BYTES, exact for 17-bit dividends
    localparam int AL = $clog2(ALIGN_BYTES);
    localparam int RS = 17 + AL;
    localparam logic [RS:0] RECIP =
        (RS + 1)'(((64'd1 << RS) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));

    typedef struct packed {
        logic [SW-1:0] start;
        logic [SW-1:0] size;
        logic          free;
    } ent_t;

    // table memory
    ent_t            mem [MAX_BLOCKS];
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    ent_t            mem_wdata;
    logic [AW-1:0]   mem_raddr;
    ent_t            mem_rdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_raddr];
    end

    // control registers
    ffpa_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [11:0]   split_reg;
    logic          init_reg, init_next;       // entry 0 still at reset value
    logic [CW-1:0] idx_reg, idx_next;         // scan / shift index
    logic          rd_pend_reg, rd_pend_next; // read of idx_reg-1 issued last cycle
    logic          cmd_reg;
    logic [SW-1:0] need_reg;
    logic [11:0]   off_reg;
    logic [AW-1:0] hit_reg, hit_next;
    ent_t          hit_e_reg, hit_e_next;
    ent_t          prev_e_reg, prev_e_next;   // entry before current scan item
    ent_t          hold_reg, hold_next;
    // shift job: dir 1 = open slot (move up), 0 = close gap (move down)
    logic          dir_reg, dir_next;
    logic [CW-1:0] lim_reg, lim_next;
    logic          step_reg, step_next;       // 0 first merge, 1 second merge
    ffpa_pkg::out_word_t res_reg, res_next;
    logic          out_valid_reg;

    // reset view of entry 0
    ent_t ent0;
    assign ent0 = '{start: '0, size: SW'(POOL_BYTES - HEADER_BYTES), free: 1'b1};

    // read data seen through the entry-0 reset mask
    logic [AW-1:0] rd_addr_reg;
    ent_t rd_e;
    always_ff @(posedge clk)
    begin
        rd_addr_reg <= mem_raddr;
    end
    assign rd_e = (init_reg && rd_addr_reg == '0) ? ent0 : mem_rdata;

    // request rounding: quotient by reciprocal multiply, then back to bytes
    logic [16:0]    rnd_x;
    logic [RS+17:0] rnd_prod;
    logic [16:0]    rnd_q;
    logic [SW-1:0]  need_c;
    assign rnd_x    = 17'(in_data.request_bytes) + 17'(ALIGN_BYTES - 1);
    assign rnd_prod = (RS + 18)'(rnd_x) * (RS + 18)'(RECIP);
    assign rnd_q    = rnd_prod[RS+16:RS];
    assign need_c   = SW'(rnd_q) * SW'(ALIGN_BYTES) + SW'(ffpa_pkg::GUARD_BYTES);

    logic [SW-1:0] hdr;
    assign hdr = SW'(HEADER_BYTES);

    assign in_ready  = (state_reg == ffpa_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    logic acc;
    assign acc = in_valid && in_ready;

    // scan hit test on the read entry
    logic hit_alloc, hit_free;
    assign hit_alloc = rd_e.free && rd_e.size >= need_reg;
    assign hit_free  = (rd_e.start + hdr) == SW'(off_reg);

    // next-state and datapath control
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        init_next    = init_reg;
        idx_next     = idx_reg;
        rd_pend_next = 1'b0;
        hit_next     = hit_reg;
        hit_e_next   = hit_e_reg;
        prev_e_next  = prev_e_reg;
        hold_next    = hold_reg;
        dir_next     = dir_reg;
        lim_next     = lim_reg;
        step_next    = step_reg;
        res_next     = res_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = hold_reg;
        mem_raddr    = idx_reg[AW-1:0];
        unique case (state_reg)
            ffpa_pkg::S_IDLE:
            begin
                if (acc)
                begin
                    res_next = '0;
                    idx_next = '0;
                    mem_raddr = '0;
                    if (in_data.cmd == ffpa_pkg::CMD_ALLOC && in_data.request_bytes == '0)
                    begin
                        res_next.status = ffpa_pkg::ST_ZERO;
                        state_next = ffpa_pkg::S_OUT;
                    end
                    else if (in_data.cmd == ffpa_pkg::CMD_FREE && in_data.data_offset_in == '0)
                    begin
                        res_next.status = ffpa_pkg::ST_NULL;
                        state_next = ffpa_pkg::S_OUT;
                    end
                    else
                    begin
                        idx_next     = CW'(1);
                        rd_pend_next = 1'b1;
                        state_next   = ffpa_pkg::S_SCAN;
                    end
                end
            end
            ffpa_pkg::S_SCAN:
            begin
                // rd_e holds entry idx_reg-1
                mem_raddr = idx_reg[AW-1:0];
                if (rd_pend_reg)
                begin
                    if ((cmd_reg == ffpa_pkg::CMD_ALLOC) ? hit_alloc : hit_free)
                    begin
                        hit_next   = AW'(idx_reg - CW'(1));
                        hit_e_next = rd_e;
                        // fetch next neighbor (idx_reg already addressed)
                        state_next = ffpa_pkg::S_DECIDE;
                    end
                    else
                    begin
                        prev_e_next = rd_e;
                        if (idx_reg >= count_reg)
                        begin
                            res_next.status = (cmd_reg == ffpa_pkg::CMD_ALLOC)
                                ? ffpa_pkg::ST_NO_FIT : ffpa_pkg::ST_INVALID;
                            state_next = ffpa_pkg::S_OUT;
                        end
                        else
                        begin
                            idx_next     = idx_reg + CW'(1);
                            rd_pend_next = 1'b1;
                        end
                    end
                end
            end
            ffpa_pkg::S_DECIDE:
            begin
                // rd_e is entry hit+1 (valid only if hit+1 < count)
                if (cmd_reg == ffpa_pkg::CMD_ALLOC)
                begin
                    hit_e_next.free = 1'b0;
                    if (count_reg < CW'(MAX_BLOCKS) && EW'(hit_e_reg.size) >=
                        EW'(need_reg) + EW'(hdr) + EW'(split_reg))
                    begin
                        hold_next = '{start: hit_e_reg.start + hdr + need_reg,
                                      size: hit_e_reg.size - need_reg - hdr,
                                      free: 1'b1};
                        hit_e_next.size = need_reg;
                        dir_next   = 1'b1;
                        // move entries count-1 .. hit+1 up by one
                        idx_next   = count_reg;
                        lim_next   = CW'(hit_reg) + CW'(1);
                        count_next = count_reg + CW'(1);
                        state_next = ffpa_pkg::S_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = ffpa_pkg::S_FINISH;
                    end
                    res_next.status = ffpa_pkg::ST_OK;
                    res_next.data_offset_out = 12'(hit_e_reg.start + hdr);
                end
                else if (hit_e_reg.free)
                begin
                    res_next.status = ffpa_pkg::ST_DOUBLE;
                    state_next = ffpa_pkg::S_OUT;
                end
                else
                begin
                    hit_e_next.free = 1'b1;
                    step_next = 1'b0;
                    if (CW'(hit_reg) + CW'(1) < count_reg && rd_e.free)
                    begin
                        // absorb next, then close gap at hit+1
                        hit_e_next.size = hit_e_reg.size + hdr + rd_e.size;
                        dir_next   = 1'b0;
                        idx_next   = CW'(hit_reg) + CW'(1);
                        lim_next   = count_reg - CW'(1);
                        count_next = count_reg - CW'(1);
                        state_next = ffpa_pkg::S_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = ffpa_pkg::S_NEIGH;
                    end
                end
            end
            ffpa_pkg::S_NEIGH:
            begin
                // previous-block merge check
                step_next = 1'b1;
                if (hit_reg != '0 && prev_e_reg.free)
                begin
                    hit_e_next = '{start: prev_e_reg.start,
                                   size: prev_e_reg.size + hdr + hit_e_reg.size,
                                   free: 1'b1};
                    // write survivor into hit-1 later, close gap at hit
                    dir_next   = 1'b0;
                    idx_next   = CW'(hit_reg);
                    lim_next   = count_reg - CW'(1);
                    count_next = count_reg - CW'(1);
                    hit_next   = hit_reg - AW'(1);
                    state_next = ffpa_pkg::S_SHIFT_RD;
                end
                else
                begin
                    state_next = ffpa_pkg::S_FINISH;
                end
            end
            ffpa_pkg::S_SHIFT_RD:
            begin
                // up: copy idx-1 -> idx while idx > lim; down: idx+1 -> idx while idx < lim
                if (dir_reg ? (idx_reg > lim_reg) : (idx_reg < lim_reg))
                begin
                    mem_raddr  = dir_reg ? AW'(idx_reg - CW'(1)) : AW'(idx_reg + CW'(1));
                    state_next = ffpa_pkg::S_SHIFT_WR;
                end
                else if (dir_reg)
                begin
                    // slot at hit+1 receives the split remainder
                    mem_we     = 1'b1;
                    mem_waddr  = AW'(lim_reg);
                    mem_wdata  = hold_reg;
                    state_next = ffpa_pkg::S_FINISH;
                end
                else if (step_reg)
                begin
                    state_next = ffpa_pkg::S_FINISH;
                end
                else
                begin
                    state_next = ffpa_pkg::S_NEIGH;
                end
            end
            ffpa_pkg::S_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(idx_reg);
                mem_wdata = rd_e;
                if (AW'(idx_reg) == '0)
                begin
                    init_next = 1'b0;
                end
                idx_next   = dir_reg ? idx_reg - CW'(1) : idx_reg + CW'(1);
                state_next = ffpa_pkg::S_SHIFT_RD;
            end
            ffpa_pkg::S_FINISH:
            begin
                mem_we    = 1'b1;
                mem_waddr = hit_reg;
                mem_wdata = hit_e_reg;
                if (hit_reg == '0)
                begin
                    init_next = 1'b0;
                end
                res_next.status = ffpa_pkg::ST_OK;
                res_next.block_bytes = 12'(hit_e_reg.size);
                state_next = ffpa_pkg::S_OUT;
            end
            ffpa_pkg::S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ffpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffpa_pkg::S_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffpa_pkg::S_IDLE;
            count_reg     <= CW'(1);
            split_reg     <= ffpa_pkg::MIN_SPLIT_RESET;
            init_reg      <= 1'b1;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            init_reg    <= init_next;
            rd_pend_reg <= rd_pend_next;
            if (cfg_we)
            begin
                split_reg <= cfg_wdata;
            end
            if (state_next == ffpa_pkg::S_OUT && state_reg != ffpa_pkg::S_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        hit_reg    <= hit_next;
        hit_e_reg  <= hit_e_next;
        prev_e_reg <= prev_e_next;
        hold_reg   <= hold_next;
        dir_reg    <= dir_next;
        lim_reg    <= lim_next;
        step_reg   <= step_next;
        res_reg    <= res_next;
        if (acc)
        begin
            cmd_reg  <= in_data.cmd;
            need_reg <= need_c;
            off_reg  <= in_data.data_offset_in;
        end
    end

    // checks
    `ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1,
        count_reg != '0 && count_reg <= CW'(MAX_BLOCKS), "block count out of range")
    `ASSERT_IMPL(a_valid_in_out, clk, rst_n, out_valid_reg,
        state_reg == ffpa_pkg::S_OUT, "result valid outside output state")
    `ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, acc,
        state_reg != ffpa_pkg::S_IDLE, "accepted word left block idle")
endmodule
`default_nettype wire
